// File: src/point_in_polygon_test_defines.svh
// Assertion macros for the point-in-polygon test block.
// Included by the checker; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define PIPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PIPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pipt_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// No dependencies.
package pipt_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_WIDTH  = 24;

    // result field widths and packing
    localparam int VUSED_W       = 7;
    localparam int OUT_FIELDS_W  = 1 + VUSED_W + 1;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W    = 2;

    // func codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic start;   // latch query point, clear walk state
        logic wr_en;   // store vertex
        logic rd_en;   // read vertex at rd_addr
        logic flush;   // evaluate last vertex against itself
    } t_dp_cmd;

    typedef struct packed {
        logic busy;    // reads or evaluation still in flight
        logic parity;  // running crossing parity
    } t_dp_stat;

endpackage

// File: src/pipt_ctrl.sv
// Controller for the point-in-polygon test: append handling, walk sequencing,
// result register. Depends on pipt_pkg.
module pipt_ctrl #(
    parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
    localparam int ADDR_W = $clog2(MAX_VERTICES),
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic                          i_restart,
    output pipt_pkg::t_dp_cmd             o_cmd,
    output logic [ADDR_W-1:0]             o_wr_addr,
    output logic [ADDR_W-1:0]             o_rd_addr,
    input  pipt_pkg::t_dp_stat            i_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_inside,
    output logic [pipt_pkg::VUSED_W-1:0]  o_vused,
    output logic                          o_ovf
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [ADDR_W-1:0]            r_addr, n_addr;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_inside, n_out_inside;
    logic [pipt_pkg::VUSED_W-1:0] r_out_vused, n_out_vused;
    logic                         r_out_ovf, n_out_ovf;
    logic                         w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_inside = r_out_inside;
        n_out_vused  = r_out_vused;
        n_out_ovf    = r_out_ovf;
        o_cmd        = '0;
        o_wr_addr    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == pipt_pkg::FUNC_APPEND) begin
                        if (i_restart) begin
                            o_cmd.wr_en = 1'b1;
                            o_wr_addr   = '0;
                            n_count     = CNT_W'(1);
                            n_ovf       = 1'b0;
                        end else if (r_count < CNT_W'(MAX_VERTICES)) begin
                            o_cmd.wr_en = 1'b1;
                            o_wr_addr   = r_count[ADDR_W-1:0];
                            n_count     = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        o_cmd.start = 1'b1;
                        n_addr      = '0;
                        n_state     = (r_count == '0) ? S_DRAIN : S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.rd_en = 1'b1;
                if (CNT_W'(r_addr) == r_count - CNT_W'(1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_LOAD: begin
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.busy && (!r_out_valid || i_out_ready)) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = i_stat.parity;
                    n_out_vused  = pipt_pkg::VUSED_W'(r_count);
                    n_out_ovf    = r_ovf;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= n_out_inside;
        r_out_vused  <= n_out_vused;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_out_valid = r_out_valid;
    assign o_inside    = r_out_inside;
    assign o_vused     = r_out_vused;
    assign o_ovf       = r_out_ovf;

endmodule

// File: src/pipt_datapath.sv
// Datapath for the point-in-polygon test: vertex memory, sliding vertex
// window and three-stage crossing evaluation. Depends on pipt_pkg.
module pipt_datapath #(
    parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = pipt_pkg::DEF_COORD_WIDTH,
    localparam int ADDR_W = $clog2(MAX_VERTICES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pipt_pkg::t_dp_cmd             i_cmd,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output pipt_pkg::t_dp_stat            o_stat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    function automatic logic signed [DW-1:0] sx(input logic signed [COORD_WIDTH-1:0] a);
        return {a[COORD_WIDTH-1], a};
    endfunction

    logic signed [COORD_WIDTH-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] r_mem_y [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] r_rd_x, r_rd_y;
    logic                          r_rd_v;

    logic signed [COORD_WIDTH-1:0] r_qx, r_qy;
    logic signed [COORD_WIDTH-1:0] r_cur_x, r_cur_y, r_prv_y;
    logic                          r_have_cur;

    // evaluation stage 0 inputs
    logic                          w_ev;
    logic signed [COORD_WIDTH-1:0] w_nxt_x, w_nxt_y;
    logic                          w_on_ray, w_straddle, w_right, w_between, w_ray_tog;

    logic                          r_e0_v, r_e0_tog, r_e0_cmp;
    logic signed [DW-1:0]          r_e0_dy0, r_e0_dx10, r_e0_dx0, r_e0_d;

    logic                          r_e1_v, r_e1_tog, r_e1_cmp, r_e1_dneg;
    logic signed [PW-1:0]          r_p1, r_p2;
    logic                          w_cmp_ok;

    logic                          r_inside;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_x[i_wr_addr] <= i_coord_x;
            r_mem_y[i_wr_addr] <= i_coord_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    // next vertex is fresh read data, or the current vertex itself on flush
    assign w_ev    = (r_rd_v || i_cmd.flush) && r_have_cur;
    assign w_nxt_x = r_rd_v ? r_rd_x : r_cur_x;
    assign w_nxt_y = r_rd_v ? r_rd_y : r_cur_y;

    assign w_on_ray   = (r_cur_y == r_qy);
    assign w_straddle = ((w_nxt_y > r_qy) && (r_cur_y < r_qy)) ||
                        ((w_nxt_y < r_qy) && (r_cur_y > r_qy));
    assign w_right    = (w_nxt_x > r_qx) && (r_cur_x > r_qx);
    assign w_between  = ((w_nxt_x >= r_qx) && (r_cur_x <= r_qx)) ||
                        ((w_nxt_x <= r_qx) && (r_cur_x >= r_qx));
    // vertex on the ray: one toggle per neighbor above
    assign w_ray_tog  = (r_cur_x >= r_qx) && ((w_nxt_y > r_qy) ^ (r_prv_y > r_qy));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
        end
        if (r_rd_v) begin
            r_prv_y <= r_have_cur ? r_cur_y : r_rd_y;
            r_cur_x <= r_rd_x;
            r_cur_y <= r_rd_y;
        end
        r_e0_tog  <= w_on_ray ? w_ray_tog : (w_straddle && w_right);
        r_e0_cmp  <= !w_on_ray && w_straddle && !w_right && w_between;
        r_e0_dy0  <= sx(r_qy) - sx(w_nxt_y);
        r_e0_dx10 <= sx(r_cur_x) - sx(w_nxt_x);
        r_e0_dx0  <= sx(r_qx) - sx(w_nxt_x);
        r_e0_d    <= sx(r_cur_y) - sx(w_nxt_y);
        r_p1      <= r_e0_dy0 * r_e0_dx10;
        r_p2      <= r_e0_dx0 * r_e0_d;
        r_e1_tog  <= r_e0_tog;
        r_e1_cmp  <= r_e0_cmp;
        r_e1_dneg <= r_e0_d[DW-1];
    end

    // intersection x >= point x, sign of the edge dy decides the direction
    assign w_cmp_ok = r_e1_dneg ? (r_p1 <= r_p2) : (r_p1 >= r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v     <= 1'b0;
            r_have_cur <= 1'b0;
            r_e0_v     <= 1'b0;
            r_e1_v     <= 1'b0;
            r_inside   <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            r_e0_v <= w_ev;
            r_e1_v <= r_e0_v;
            if (i_cmd.start) begin
                r_have_cur <= 1'b0;
                r_inside   <= 1'b0;
            end else begin
                if (r_rd_v) begin
                    r_have_cur <= 1'b1;
                end
                if (r_e1_v) begin
                    r_inside <= r_inside ^ (r_e1_tog || (r_e1_cmp && w_cmp_ok));
                end
            end
        end
    end

    assign o_stat.busy   = r_rd_v || r_e0_v || r_e1_v;
    assign o_stat.parity = r_inside;

endmodule

// File: src/point_in_polygon_test.sv
// Top level of the point-in-polygon test block: stream ports, controller and
// datapath. Depends on pipt_pkg, pipt_ctrl, pipt_datapath.
//
// Point-in-polygon test by horizontal ray crossing on signed Q12.12 points.
// An append transfer (func = 0) stores one vertex; restart = 1 empties the
// list and clears the overflow flag first. Appends past MAX_VERTICES are
// dropped and set a sticky overflow flag. A query transfer (func = 1) walks
// the n stored vertices in order, one memory read per cycle, pairing each
// with its next (the last with itself) and its previous (the first with
// itself), so a closed polygon must repeat its first point. The edge
// intersection test is an exact cross-multiplied compare. The time from a
// query's acceptance to the next acceptance is set by the walk over the
// single vertex memory read port, plus a three-stage evaluation pipe
// drained at the end, and it waits while an earlier result is not taken.
// Appends produce no result; a query produces one result transfer. The input
// is not taken while a query runs; a finished result waits in an output
// register and does not block appends. There is no reset sweep: vertices
// are only read below the stored count.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = pipt_pkg::DEF_COORD_WIDTH,
    localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int ADDR_W      = $clog2(MAX_VERTICES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: coord_x [COORD_WIDTH-1:0], coord_y, zero pad
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
    // tuser: func [0], restart [1]
    input  logic [pipt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // result item
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: inside_res [0], vertices_used [7:1], overflowed [8], zero pad
    output logic [pipt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    pipt_pkg::t_dp_cmd              w_cmd;
    pipt_pkg::t_dp_stat             w_stat;
    logic [ADDR_W-1:0]              w_wr_addr, w_rd_addr;
    logic signed [COORD_WIDTH-1:0]  w_coord_x, w_coord_y;
    logic                           w_inside, w_ovf;
    logic [pipt_pkg::VUSED_W-1:0]   w_vused;

    // pad bits of tdata above the two coordinates are ignored
    assign w_coord_x = s_axis_tdata[COORD_WIDTH-1:0];
    assign w_coord_y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    pipt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser[0]),
        .i_restart   (s_axis_tuser[1]),
        .o_cmd       (w_cmd),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .i_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_inside    (w_inside),
        .o_vused     (w_vused),
        .o_ovf       (w_ovf)
    );

    pipt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_wr_addr (w_wr_addr),
        .i_rd_addr (w_rd_addr),
        .i_coord_x (w_coord_x),
        .i_coord_y (w_coord_y),
        .o_stat    (w_stat)
    );

    assign m_axis_tdata = {{(pipt_pkg::OUT_TDATA_W - pipt_pkg::OUT_FIELDS_W){1'b0}},
                           w_ovf, w_vused, w_inside};

endmodule

// File: src/pipt_checker.sv
// Port-level checks for point_in_polygon_test, bound to the top level.
// Depends on pipt_pkg and point_in_polygon_test_defines.svh.
`include "point_in_polygon_test_defines.svh"

module pipt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [pipt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pipt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    `PIPT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a query occupies the block for at least the next cycle
    `PIPT_ASSERT(a_query_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == pipt_pkg::FUNC_QUERY) |=> !s_axis_tready, "input taken right after a query")

    // an append never raises a result
    `PIPT_ASSERT(a_append_silent, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == pipt_pkg::FUNC_APPEND) && !m_axis_tvalid |=> !m_axis_tvalid, "append produced a result")

    // reset leaves the block idle with no result pending
    `PIPT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

endmodule

bind point_in_polygon_test pipt_checker u_pipt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/point_in_polygon_test_tb.sv
// Self-checking bench for point_in_polygon_test: polygon appends and ray-crossing queries.
// Uses pipt_pkg for codes and widths; needs the point_in_polygon_test RTL only.
module point_in_polygon_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW             = pipt_pkg::DEF_COORD_WIDTH;
    localparam int MAXV           = pipt_pkg::DEF_MAX_VERTICES;
    localparam int VUSED_W        = pipt_pkg::VUSED_W;
    localparam int IN_TDATA_W     = ((2 * CW + 7) / 8) * 8;
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int RX_HOLD_CYCLES = 300;  // long output stall so the block backs up
    localparam int TAIL_CYCLES    = 100;  // margin after the last query for its walk and result
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_REPORTS    = 100;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};

    // one query verdict as it comes out of m_axis_tdata
    typedef struct packed {
        logic               in_poly;
        logic [VUSED_W-1:0] used;
        logic               ovf;
    } t_verdict;

    // one line of the directed table; typed rows carry their verdict
    typedef struct packed {
        logic               func;
        logic               restart;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [7:0]         reps;
        logic               typed;
        logic               exp_in_poly;
        logic [VUSED_W-1:0] exp_used;
        logic               exp_ovf;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: coord_x [CW-1:0], coord_y [2*CW-1:CW]
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    // tuser: func [0], restart [1]
    logic [pipt_pkg::IN_TUSER_W-1:0] s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: inside_res [0], vertices_used [7:1], overflowed [8], zero pad
    logic [pipt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // bench copy of the vertex list
    logic signed [CW-1:0] poly_x [MAXV];
    logic signed [CW-1:0] poly_y [MAXV];
    int                   poly_len = 0;
    logic                 poly_ovf = 1'b0;

    t_verdict pending_verdicts [$];
    int       mismatch_count  = 0;
    int       items_sent      = 0;
    int       cycle_count     = 0;
    int       tx_idle_pct     = 0;
    int       rx_idle_pct     = 0;
    bit       rx_hold_request = 1'b0;

    // Directed rows: empty list, a unit square, a full-range triangle, a
    // single vertex, a full store with one dropped append, then a restart
    // that clears the overflow flag. Queries with restart set check that the
    // bit is ignored.
    t_stim_row directed_rows [27] = '{
        '{pipt_pkg::FUNC_QUERY,  1'b1, 'h0,     'h0,    8'd1,  1'b1, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b1, 'h0,     'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, 'h1000,  'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, 'h1000,  'h1000, 8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, 'h0,     'h1000, 8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, 'h0,     'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h800,   'h800,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h1800,  'h800,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, -'sh100, 'h1000, 8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h800,   'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, C_MIN,   C_MAX,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, C_MAX,   C_MIN,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b1, C_MIN,   C_MIN,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, C_MAX,   'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, C_MIN,   C_MAX,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, C_MIN,   C_MIN,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h0,     'h0,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, C_MIN,   'h123,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, -'sh1,   -'sh1,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, C_MAX,   C_MAX,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b1, 'h5,     'h5,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h5,     'h5,    8'd1,  1'b1, 1'b0, 7'd1,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b1, 'h100,   'h100,  8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_APPEND, 1'b0, 'h100,   'h100,  8'd64, 1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b0, 'h0,     'h100,  8'd1,  1'b1, 1'b0, 7'd64, 1'b1},
        '{pipt_pkg::FUNC_APPEND, 1'b1, -'sh7,   'h3,    8'd1,  1'b0, 1'b0, 7'd0,  1'b0},
        '{pipt_pkg::FUNC_QUERY,  1'b1, 'h0,     'h0,    8'd1,  1'b1, 1'b0, 7'd1,  1'b0}
    };

    point_in_polygon_test #(
        .MAX_VERTICES (MAXV),
        .COORD_WIDTH  (CW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Crossing parity of the rightward ray from (qx, qy). Each vertex pairs
    // with its next (last with itself) and its previous (first with itself).
    // The intersection test is cross-multiplied; 25-bit differences give
    // products well inside 64 bits.
    function automatic logic ray_parity(input logic signed [CW-1:0] qx,
                                        input logic signed [CW-1:0] qy);
        longint xx, yy, x0, y0, x1, y1, y2, dy, lhs, rhs;
        int     nx, pv;
        logic   par;
        xx  = longint'(qx);
        yy  = longint'(qy);
        par = 1'b0;
        for (int i = 0; i < poly_len; i++) begin
            nx = (i + 1 < poly_len) ? i + 1 : i;
            pv = (i > 0) ? i - 1 : i;
            x1 = longint'(poly_x[i]);
            y1 = longint'(poly_y[i]);
            x0 = longint'(poly_x[nx]);
            y0 = longint'(poly_y[nx]);
            y2 = longint'(poly_y[pv]);
            if (y1 != yy) begin
                // edge strictly straddles the ray
                if ((y0 > yy && y1 < yy) || (y0 < yy && y1 > yy)) begin
                    if (x0 > xx && x1 > xx) begin
                        par = ~par;
                    end else if ((x0 >= xx && x1 <= xx) || (x0 <= xx && x1 >= xx)) begin
                        // intersection x >= xx without the divide
                        dy  = y1 - y0;
                        lhs = (yy - y0) * (x1 - x0);
                        rhs = (xx - x0) * dy;
                        if ((dy > 0 && lhs >= rhs) || (dy < 0 && lhs <= rhs))
                            par = ~par;
                    end
                end
            end else if (x1 >= xx) begin
                // vertex sits on the ray: one toggle per neighbor above
                if (y0 > yy)
                    par = ~par;
                if (y2 > yy)
                    par = ~par;
            end
        end
        return par;
    endfunction

    // Apply one accepted transfer to the bench vertex list; queries yield a verdict.
    task automatic predict_polygon_step(input logic func, input logic restart,
                                        input logic signed [CW-1:0] px,
                                        input logic signed [CW-1:0] py,
                                        output bit has_verdict, output t_verdict verdict);
        has_verdict = 1'b0;
        verdict     = '0;
        if (func == pipt_pkg::FUNC_APPEND) begin
            if (restart) begin
                poly_len = 0;
                poly_ovf = 1'b0;
            end
            if (poly_len < MAXV) begin
                poly_x[poly_len] = px;
                poly_y[poly_len] = py;
                poly_len++;
            end else begin
                poly_ovf = 1'b1;  // dropped append, sticky until restart
            end
        end else begin
            has_verdict     = 1'b1;
            verdict.in_poly = ray_parity(px, py);
            verdict.used    = poly_len[VUSED_W-1:0];
            verdict.ovf     = poly_ovf;
        end
    endtask

    function automatic logic signed [CW-1:0] any_coord();
        return CW'($urandom);
    endfunction

    // base plus a uniform offset in [-span, span], wrapped to the field width
    function automatic logic signed [CW-1:0] near_coord(input logic signed [CW-1:0] base,
                                                        input int span);
        int off;
        off = int'($urandom_range(2 * span)) - span;
        return base + off[CW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        // keep the log short if the design is badly off
        if (mismatch_count <= MAX_REPORTS)
            $display("tb mismatch at cycle %0d: %s: got %0d, expected %0d",
                     cycle_count, what, got, want);
    endtask

    // Offer one item after a random idle gap, hold it until the transfer,
    // then update the bench model. Only one nonblocking write per signal per
    // edge: tvalid stays high from one item to the next when there is no gap.
    task automatic send_item(input logic func, input logic restart,
                             input logic signed [CW-1:0] px,
                             input logic signed [CW-1:0] py,
                             input bit typed = 1'b0, input t_verdict typed_verdict = '0);
        logic [IN_TDATA_W-1:0] word;
        t_verdict              verdict;
        bit                    has_verdict;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word                = '0;
        word[CW-1:0]        = px;
        word[2*CW-1:CW]     = py;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {restart, func};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_polygon_step(func, restart, px, py, has_verdict, verdict);
        if (has_verdict)
            pending_verdicts.push_back(typed ? typed_verdict : verdict);
        items_sent++;
    endtask

    // Sender pause: nothing offered until every verdict has come back.
    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // One well-formed round: restart plus a few vertices around a center,
    // usually closed by repeating the first point, then queries that hit
    // vertex rows, vertex columns, vertices themselves and open space.
    // Now and then the round runs past capacity to exercise the overflow flag.
    task automatic polygon_round();
        int                   n_vert, n_query, span, vi;
        logic signed [CW-1:0] cx, cy, vx, vy, fx, fy, qx, qy;
        n_vert = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        span   = 1 << $urandom_range(2, 16);
        if ($urandom_range(3) == 0) begin
            cx = any_coord();
            cy = any_coord();
        end else begin
            cx = near_coord('0, 4096);
            cy = near_coord('0, 4096);
        end
        fx = '0;
        fy = '0;
        for (int v = 0; v < n_vert; v++) begin
            vx = near_coord(cx, span);
            vy = near_coord(cy, span);
            if (v == 0) begin
                fx = vx;
                fy = vy;
            end
            send_item(pipt_pkg::FUNC_APPEND, v == 0, vx, vy);
        end
        if ($urandom_range(9) < 7)
            send_item(pipt_pkg::FUNC_APPEND, 1'b0, fx, fy);
        n_query = $urandom_range(1, 6);
        for (int q = 0; q < n_query; q++) begin
            vi = $urandom_range(poly_len - 1);
            qx = near_coord(cx, span + span / 2);
            qy = near_coord(cy, span + span / 2);
            case ($urandom_range(4))
                0: ;
                1: qy = poly_y[vi];
                2: qx = poly_x[vi];
                3: begin
                    qx = poly_x[vi];
                    qy = poly_y[vi];
                end
                default: begin
                    qx = any_coord();
                    qy = any_coord();
                end
            endcase
            send_item(pipt_pkg::FUNC_QUERY, 1'($urandom_range(1)), qx, qy);
        end
    endtask

    // Mostly polygon rounds; the rest is noise: any op, any restart, any point.
    task automatic run_random_phase(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0)
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                          any_coord(), any_coord());
            else
                polygon_round();
        end
    endtask

    // Result side: random tready, or a long hold-off when requested.
    initial begin : rx_side
        int held;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++)
                    @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: every result transfer against the oldest verdict.
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.in_poly = m_axis_tdata[0];
            got.used    = m_axis_tdata[VUSED_W:1];
            got.ovf     = m_axis_tdata[VUSED_W+1];
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no query pending", int'(got.used), -1);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.in_poly !== want.in_poly)
                    report_mismatch("inside_res", int'(got.in_poly), int'(want.in_poly));
                if (got.used !== want.used)
                    report_mismatch("vertices_used", int'(got.used), int'(want.used));
                if (got.ovf !== want.ovf)
                    report_mismatch("overflowed", int'(got.ovf), int'(want.ovf));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : main_seq
        t_verdict typed_verdict;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_rst_n       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling on either side
        foreach (directed_rows[r]) begin
            typed_verdict = '{directed_rows[r].exp_in_poly, directed_rows[r].exp_used,
                              directed_rows[r].exp_ovf};
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].func, directed_rows[r].restart,
                          directed_rows[r].x, directed_rows[r].y,
                          directed_rows[r].typed, typed_verdict);
        end
        drain_verdicts();

        // sender mostly busy, receiver mostly stalled
        tx_idle_pct = 21;
        rx_idle_pct = 87;
        run_random_phase(RANDOM_ITEMS / 3);
        drain_verdicts();

        // the other way round
        tx_idle_pct = 87;
        rx_idle_pct = 21;
        run_random_phase(RANDOM_ITEMS / 3);
        drain_verdicts();

        // full rate, opening with a long output stall so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_request = 1'b1;
        run_random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_verdicts();

        // room for any stray result after the last query
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0)
            report_mismatch("verdicts never delivered", pending_verdicts.size(), 0);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
